[design/one_wire_bus_master_macros.svh]
// Assertion macros used by the one-wire bus master engine.
`ifndef ONE_WIRE_BUS_MASTER_MACROS_SVH
`define ONE_WIRE_BUS_MASTER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define OWM_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define OWM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/owm_pkg.sv]
// Package with the shared types, constants and CRC function of the one-wire bus master.
package owm_pkg;

   // Counter width default for the tick counter.
   localparam int TICK_COUNT_BITS_DEFAULT = 10;

   // Operation and command codes share one encoding.
   typedef enum logic [1:0] {
      OP_IDLE  = 2'd0,
      OP_RESET = 2'd1,
      OP_WRITE = 2'd2,
      OP_READ  = 2'd3
   } op_type;

   // Register indexes of the control port.
   localparam logic [2:0] CSR_RESET_LOW       = 3'd0;
   localparam logic [2:0] CSR_PRESENCE_SAMPLE = 3'd1;
   localparam logic [2:0] CSR_RESET_RECOVER   = 3'd2;
   localparam logic [2:0] CSR_SLOT            = 3'd3;
   localparam logic [2:0] CSR_SHORT_LOW       = 3'd4;
   localparam logic [2:0] CSR_READ_SAMPLE     = 3'd5;

   // Register values after reset.
   localparam logic [9:0] RESET_LOW_DEFAULT       = 10'd480;
   localparam logic [9:0] PRESENCE_SAMPLE_DEFAULT = 10'd70;
   localparam logic [9:0] RESET_RECOVER_DEFAULT   = 10'd410;
   localparam logic [9:0] SLOT_DEFAULT            = 10'd120;
   localparam logic [5:0] SHORT_LOW_DEFAULT       = 6'd2;
   localparam logic [9:0] READ_SAMPLE_DEFAULT     = 10'd14;

   // Reflected Dallas CRC-8 polynomial.
   localparam logic [7:0] CRC_POLY = 8'h8C;

   typedef struct packed {
      logic [9:0] reset_low_ticks;
      logic [9:0] presence_sample_ticks;
      logic [9:0] reset_recover_ticks;
      logic [9:0] slot_ticks;
      logic [5:0] short_low_ticks;
      logic [9:0] read_sample_ticks;
   } cfg_type;

   typedef struct packed {
      logic       pull_low;
      logic       busy_res;
      logic       done_res;
      logic       presence;
      logic [7:0] read_value;
      logic [7:0] crc_value;
      logic       rejected;
   } res_type;

   // Folds one byte into the CRC, least significant bit first.
   function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      logic [7:0] d;
      logic       mix;
      c = crc;
      d = b;
      for (int i = 0; i < 8; i++) begin
         mix = c[0] ^ d[0];
         c   = {1'b0, c[7:1]};
         if (mix) begin
            c = c ^ CRC_POLY;
         end
         d = {1'b0, d[7:1]};
      end
      return c;
   endfunction

endpackage

[design/owm_req_if.sv]
// Request channel interface of the one-wire bus master.
interface owm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] mode;
   logic [7:0] data_byte;
   logic       line_level;

   modport source (output valid, output mode, output data_byte, output line_level,
                   input ready);
   modport sink (input valid, input mode, input data_byte, input line_level,
                 output ready);
endinterface

[design/owm_rsp_if.sv]
// Response channel interface of the one-wire bus master.
interface owm_rsp_if;
   logic       valid;
   logic       ready;
   logic       pull_low;
   logic       busy_res;
   logic       done_res;
   logic       presence;
   logic [7:0] read_value;
   logic [7:0] crc_value;
   logic       rejected;

   modport source (output valid, output pull_low, output busy_res, output done_res,
                   output presence, output read_value, output crc_value,
                   output rejected, input ready);
   modport sink (input valid, input pull_low, input busy_res, input done_res,
                 input presence, input read_value, input crc_value,
                 input rejected, output ready);
endinterface

[design/one_wire_bus_master.sv]
// Top level of the one-wire bus master: control registers, request handshake and response register.
//
//   port      direction  carries
//   req_if    in         mode, data_byte, line_level (one request per microsecond tick)
//   rsp_if    out        pull_low, busy_res, done_res, presence, read_value, crc_value, rejected
//   csr_*     in         writes to the six timing registers
//
// Every request is worked combinationally: the engine's next-state logic feeds the response
// register directly, so one request can be taken in every cycle while the response side takes responses.
// A response is ready in the cycle after its request is taken; a request is still taken while
// a response waits, provided the response side takes it in the same cycle.
// Synchronous reset returns the engine to idle, clears CRC, presence and the last byte read,
// and loads the timing registers with their default values.
module one_wire_bus_master
   import owm_pkg::*;
#(
   parameter int TICK_COUNT_BITS = TICK_COUNT_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   owm_req_if.sink    req_if,
   owm_rsp_if.source  rsp_if,
   input  logic       csr_write_en,
   input  logic [2:0] csr_index,
   input  logic [9:0] csr_write_data
);

   cfg_type cfg_ff;
   res_type rsp_data_ff;
   res_type result;
   logic    rsp_valid_ff;
   logic    accept;

   // Timing registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reset_low_ticks       <= RESET_LOW_DEFAULT;
         cfg_ff.presence_sample_ticks <= PRESENCE_SAMPLE_DEFAULT;
         cfg_ff.reset_recover_ticks   <= RESET_RECOVER_DEFAULT;
         cfg_ff.slot_ticks            <= SLOT_DEFAULT;
         cfg_ff.short_low_ticks       <= SHORT_LOW_DEFAULT;
         cfg_ff.read_sample_ticks     <= READ_SAMPLE_DEFAULT;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_RESET_LOW:       cfg_ff.reset_low_ticks       <= csr_write_data;
            CSR_PRESENCE_SAMPLE: cfg_ff.presence_sample_ticks <= csr_write_data;
            CSR_RESET_RECOVER:   cfg_ff.reset_recover_ticks   <= csr_write_data;
            CSR_SLOT:            cfg_ff.slot_ticks            <= csr_write_data;
            CSR_SHORT_LOW:       cfg_ff.short_low_ticks       <= csr_write_data[5:0];
            CSR_READ_SAMPLE:     cfg_ff.read_sample_ticks     <= csr_write_data;
            default: ;
         endcase
      end
   end

   // A request is taken when the response register is empty or being emptied.
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   owm_engine #(
      .TICK_COUNT_BITS (TICK_COUNT_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .mode       (req_if.mode),
      .data_byte  (req_if.data_byte),
      .line_level (req_if.line_level),
      .cfg        (cfg_ff),
      .result     (result)
   );

   // Response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (accept) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.pull_low   = rsp_data_ff.pull_low;
   assign rsp_if.busy_res   = rsp_data_ff.busy_res;
   assign rsp_if.done_res   = rsp_data_ff.done_res;
   assign rsp_if.presence   = rsp_data_ff.presence;
   assign rsp_if.read_value = rsp_data_ff.read_value;
   assign rsp_if.crc_value  = rsp_data_ff.crc_value;
   assign rsp_if.rejected   = rsp_data_ff.rejected;

endmodule

[design/owm_engine.sv]
// Bus timing engine: operation state, slot and reset timing, shift register and CRC.
`include "one_wire_bus_master_macros.svh"

module owm_engine
   import owm_pkg::*;
#(
   parameter int TICK_COUNT_BITS = TICK_COUNT_BITS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [1:0] mode,
   input  logic [7:0] data_byte,
   input  logic       line_level,
   input  cfg_type    cfg,
   output res_type    result
);

   // Compare width covers both the counter and the ten-bit registers.
   localparam int CW = (TICK_COUNT_BITS > 10) ? TICK_COUNT_BITS : 10;
   localparam logic [CW-1:0] TC_MAX = CW'((64'd1 << TICK_COUNT_BITS) - 64'd1);
   localparam logic [CW-1:0] CW_ONE = CW'(1);

   typedef enum logic [2:0] {
      PH_LOW     = 3'd0,
      PH_SAMPLE  = 3'd1,
      PH_RECOVER = 3'd2
   } phase_type;

   op_type                     operation_ff, operation_in;
   phase_type                  phase_ff, phase_in;
   logic [TICK_COUNT_BITS-1:0] tick_count_ff;
   logic [CW-1:0]              tick_count_in;
   logic [2:0]                 bit_index_ff, bit_index_in;
   logic [7:0]                 shift_byte_ff, shift_byte_in;
   logic [7:0]                 crc_accum_ff, crc_accum_in;
   logic                       presence_flag_ff, presence_flag_in;
   logic [7:0]                 read_hold_ff, read_hold_in;

   logic [CW-1:0] low_lim, sample_lim, recover_lim, slot_lim, read_at, short_lim;
   logic [CW-1:0] count, count_inc;
   logic          pull, done, rej;

   // Limits clipped to what the tick counter can hold; low and slot limits are kept at least one.
   always_comb begin
      low_lim     = (CW'(cfg.reset_low_ticks) > TC_MAX) ? TC_MAX : CW'(cfg.reset_low_ticks);
      if (low_lim == '0) begin
         low_lim = CW_ONE;
      end
      sample_lim  = (CW'(cfg.presence_sample_ticks) > TC_MAX) ?
                    TC_MAX : CW'(cfg.presence_sample_ticks);
      recover_lim = (CW'(cfg.reset_recover_ticks) > TC_MAX) ?
                    TC_MAX : CW'(cfg.reset_recover_ticks);
      slot_lim    = (CW'(cfg.slot_ticks) > TC_MAX) ? TC_MAX : CW'(cfg.slot_ticks);
      if (slot_lim == '0) begin
         slot_lim = CW_ONE;
      end
      // A late read sample falls on the last slot position.
      read_at     = (CW'(cfg.read_sample_ticks) > slot_lim - CW_ONE) ?
                    slot_lim - CW_ONE : CW'(cfg.read_sample_ticks);
      short_lim   = CW'(cfg.short_low_ticks);
   end

   // One tick of work: start a command if idle or reject it if busy, then advance the running operation.
   always_comb begin
      operation_in     = operation_ff;
      phase_in         = phase_ff;
      tick_count_in    = CW'(tick_count_ff);
      bit_index_in     = bit_index_ff;
      shift_byte_in    = shift_byte_ff;
      crc_accum_in     = crc_accum_ff;
      presence_flag_in = presence_flag_ff;
      read_hold_in     = read_hold_ff;
      pull             = 1'b0;
      done             = 1'b0;
      rej              = 1'b0;

      if (op_type'(mode) != OP_IDLE) begin
         if (operation_ff != OP_IDLE) begin
            rej = 1'b1;
         end else begin
            operation_in  = op_type'(mode);
            phase_in      = PH_LOW;
            tick_count_in = '0;
            bit_index_in  = '0;
            case (op_type'(mode))
               OP_RESET: begin
                  crc_accum_in     = '0;
                  presence_flag_in = 1'b0;
               end
               OP_WRITE: shift_byte_in = data_byte;
               default:  shift_byte_in = '0;
            endcase
         end
      end

      count     = tick_count_in;
      count_inc = count + CW_ONE;

      case (operation_in)
         OP_RESET: begin
            case (phase_in)
               PH_LOW: begin
                  pull = 1'b1;
                  if (count_inc >= low_lim) begin
                     phase_in      = PH_SAMPLE;
                     tick_count_in = '0;
                  end else begin
                     tick_count_in = count_inc;
                  end
               end
               PH_SAMPLE: begin
                  if (count >= sample_lim) begin
                     // A low line on the sample tick means a device answered.
                     presence_flag_in = !line_level;
                     if (!line_level && recover_lim != '0) begin
                        phase_in      = PH_RECOVER;
                        tick_count_in = '0;
                     end else begin
                        operation_in  = OP_IDLE;
                        phase_in      = PH_LOW;
                        tick_count_in = '0;
                        done          = 1'b1;
                     end
                  end else begin
                     tick_count_in = count_inc;
                  end
               end
               PH_RECOVER: begin
                  if (count_inc >= recover_lim) begin
                     operation_in  = OP_IDLE;
                     phase_in      = PH_LOW;
                     tick_count_in = '0;
                     done          = 1'b1;
                  end else begin
                     tick_count_in = count_inc;
                  end
               end
               default: begin
                  operation_in  = OP_IDLE;
                  phase_in      = PH_LOW;
                  tick_count_in = '0;
                  done          = 1'b1;
               end
            endcase
         end
         OP_WRITE, OP_READ: begin
            if (operation_in == OP_WRITE) begin
               pull = shift_byte_in[0] ? (count < short_lim) : 1'b1;
            end else begin
               pull = count < short_lim;
               if (count == read_at) begin
                  shift_byte_in = {line_level, shift_byte_in[7:1]};
               end
            end
            // End of a bit slot.
            if (count_inc >= slot_lim) begin
               tick_count_in = '0;
               if (operation_in == OP_WRITE) begin
                  shift_byte_in = {1'b0, shift_byte_in[7:1]};
               end
               if (bit_index_in == 3'd7) begin
                  bit_index_in = '0;
                  if (operation_in == OP_READ) begin
                     read_hold_in = shift_byte_in;
                     crc_accum_in = crc_byte(crc_accum_in, shift_byte_in);
                  end
                  operation_in = OP_IDLE;
                  phase_in     = PH_LOW;
                  done         = 1'b1;
               end else begin
                  bit_index_in = bit_index_in + 3'd1;
               end
            end else begin
               tick_count_in = count_inc;
            end
         end
         default: ;
      endcase
   end

   // The result shows the state after this tick.
   always_comb begin
      result.pull_low   = pull;
      result.busy_res   = operation_in != OP_IDLE;
      result.done_res   = done;
      result.presence   = presence_flag_in;
      result.read_value = read_hold_in;
      result.crc_value  = crc_accum_in;
      result.rejected   = rej;
   end

   // Engine state advances once for every accepted request.
   always_ff @(posedge clock) begin
      if (reset) begin
         operation_ff     <= OP_IDLE;
         phase_ff         <= PH_LOW;
         tick_count_ff    <= '0;
         bit_index_ff     <= '0;
         shift_byte_ff    <= '0;
         crc_accum_ff     <= '0;
         presence_flag_ff <= 1'b0;
         read_hold_ff     <= '0;
      end else if (accept) begin
         operation_ff     <= operation_in;
         phase_ff         <= phase_in;
         tick_count_ff    <= tick_count_in[TICK_COUNT_BITS-1:0];
         bit_index_ff     <= bit_index_in;
         shift_byte_ff    <= shift_byte_in;
         crc_accum_ff     <= crc_accum_in;
         presence_flag_ff <= presence_flag_in;
         read_hold_ff     <= read_hold_in;
      end
   end

   `OWM_ASSERT_NOW(a_done_not_busy, accept && result.done_res, !result.busy_res, "done while still busy")
   `OWM_ASSERT_NOW(a_reject_when_busy, accept && result.rejected, operation_ff != OP_IDLE, "rejected while idle")
   `OWM_ASSERT_NOW(a_bits_only_in_slots, bit_index_ff != 3'd0, operation_ff == OP_WRITE || operation_ff == OP_READ, "bit index outside a byte operation")
   `OWM_ASSERT_NEXT(a_reset_clears_crc, accept && operation_ff == OP_IDLE && op_type'(mode) == OP_RESET, crc_accum_ff == 8'd0, "bus reset left the CRC uncleared")

endmodule
